@@ design/rpwc_pkg.sv @@
`timescale 1ns / 1ps

package rpwc_pkg;

    localparam int CH_W        = 2;    // channel code width
    localparam int SEL_W       = 5;    // compares channel codes against counts up to 31
    localparam int TICK_W      = 16;   // timer ticks
    localparam int MS_W        = 32;   // millisecond stamps
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [TICK_W-1:0] DEF_MIN_WIDTH = 16'd900;
    localparam logic [TICK_W-1:0] DEF_MAX_WIDTH = 16'd2100;
    localparam logic [TICK_W-1:0] RESET_WIDTH   = 16'd1500;
    localparam logic [TICK_W-1:0] RESET_PERIOD  = 16'hFFFF;
    localparam logic [MS_W-1:0]   RESET_TIMEOUT = 32'd100;

    typedef enum logic
    {
        OP_CAPTURE = 1'b0,
        OP_POLL    = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_COUNTER_PERIOD = 2'd0,
        CFG_VALID_MIN      = 2'd1,
        CFG_VALID_MAX      = 2'd2,
        CFG_TIMEOUT        = 2'd3
    } cfg_reg_t;

    typedef struct packed
    {
        logic [TICK_W-1:0] counter_period;
        logic [TICK_W-1:0] valid_min_width;
        logic [TICK_W-1:0] valid_max_width;
        logic [MS_W-1:0]   activity_timeout_ms;
    } cfg_t;

    // classified item as it travels from front to back
    typedef struct packed
    {
        op_t               op;
        logic              ch_ok;
        logic [CH_W-1:0]   channel;
        logic [TICK_W-1:0] capture_value;
        logic [MS_W-1:0]   now_ms;
    } work_t;

    typedef struct packed
    {
        logic [CH_W-1:0]   out_channel;
        logic [TICK_W-1:0] pulse_width;
        logic              fault;
        logic              active;
        logic              width_updated;
        logic              awaiting_falling;
    } result_t;

endpackage

@@ design/rpwc_in_if.sv @@
`timescale 1ns / 1ps

interface rpwc_in_if
    import rpwc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [CH_W-1:0]   channel;
    logic [TICK_W-1:0] capture_value;
    logic [MS_W-1:0]   now_ms;

    modport source (output valid, output operation, output channel,
                    output capture_value, output now_ms, input ready);
    modport sink   (input valid, input operation, input channel,
                    input capture_value, input now_ms, output ready);
endinterface

@@ design/rpwc_out_if.sv @@
`timescale 1ns / 1ps

interface rpwc_out_if
    import rpwc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   out_channel;
    logic [TICK_W-1:0] pulse_width;
    logic              fault;
    logic              active;
    logic              width_updated;
    logic              awaiting_falling;

    modport source (output valid, output out_channel, output pulse_width,
                    output fault, output active, output width_updated,
                    output awaiting_falling, input ready);
    modport sink   (input valid, input out_channel, input pulse_width,
                    input fault, input active, input width_updated,
                    input awaiting_falling, output ready);
endinterface

@@ design/rc_pulse_width_capture.sv @@
`timescale 1ns / 1ps
// RC pulse width capture, NUM_CHANNELS servo inputs.
// Channel "item" (sink): one beat per timer edge capture (operation 0) or
// status poll (operation 1), with channel, capture value and the current
// millisecond stamp. Channel "result" (source): exactly one beat per item,
// in order, carrying the channel's held width, fault, activity, whether
// this beat stored a new width, and whether the channel now waits for a
// falling edge. Out-of-range channels give an all-zero status.
// Configuration: cfg_we / cfg_index / cfg_wdata write counter period,
// window minimum, window maximum and activity timeout; write only while idle.
// Throughput: one item per cycle while result.ready stays high. A front
// stage classifies each beat into a two-entry queue; the back stage does
// the per-channel read-modify-write and loads the output register.
// Each item waits at the queue head and then in the output register before
// its result beat can be taken.
// Stall: if result.ready stays low the output register holds, the queue
// fills after two more items and item.ready then drops; nothing is lost.
// Reset: all channels wait for a rising edge, hold width 1500, have no
// good-pulse time and no fault; configuration returns to its defaults.
// Reset needs no clearing pass; items are accepted right after it.

module rc_pulse_width_capture
    import rpwc_pkg::*;
#(
    parameter int NUM_CHANNELS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    rpwc_in_if.sink               item,
    rpwc_out_if.source            result
);

    cfg_t  cfg_reg, cfg_next;

    logic  q_full;
    logic  q_push;
    work_t q_push_data;
    logic  q_pop;
    logic  q_head_valid;
    work_t q_head;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_COUNTER_PERIOD: cfg_next.counter_period      = cfg_wdata[TICK_W-1:0];
                CFG_VALID_MIN:      cfg_next.valid_min_width     = cfg_wdata[TICK_W-1:0];
                CFG_VALID_MAX:      cfg_next.valid_max_width     = cfg_wdata[TICK_W-1:0];
                CFG_TIMEOUT:        cfg_next.activity_timeout_ms = cfg_wdata[MS_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.counter_period      <= RESET_PERIOD;
            cfg_reg.valid_min_width     <= '0;
            cfg_reg.valid_max_width     <= '0;
            cfg_reg.activity_timeout_ms <= RESET_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and classify
    rpwc_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .item      (item),
        .full      (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // decoupling queue
    rpwc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // back: channel state update and result register
    rpwc_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .result     (result)
    );

endmodule

@@ design/rpwc_front.sv @@
`timescale 1ns / 1ps

module rpwc_front
    import rpwc_pkg::*;
#(
    parameter int NUM_CHANNELS = 3
)
(
    rpwc_in_if.sink item,
    input  logic    full,
    output logic    push,
    output work_t   push_data
);

    // accept whenever the queue has room
    assign item.ready = !full;
    assign push       = item.valid && !full;

    always_comb
    begin
        push_data.op            = op_t'(item.operation);
        push_data.ch_ok         = SEL_W'(item.channel) < SEL_W'(NUM_CHANNELS);
        push_data.channel       = item.channel;
        push_data.capture_value = item.capture_value;
        push_data.now_ms        = item.now_ms;
    end

endmodule

@@ design/rpwc_queue.sv @@
`timescale 1ns / 1ps

module rpwc_queue
    import rpwc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output work_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/rpwc_back.sv @@
`timescale 1ns / 1ps

module rpwc_back
    import rpwc_pkg::*;
#(
    parameter int NUM_CHANNELS = 3
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     head_valid,
    input  work_t    head,
    output logic     pop,
    rpwc_out_if.source result
);

    // per-channel state
    logic              wait_falling_reg   [NUM_CHANNELS];
    logic [TICK_W-1:0] rise_stamp_reg     [NUM_CHANNELS];
    logic [TICK_W-1:0] held_width_reg     [NUM_CHANNELS];
    logic [MS_W-1:0]   last_good_time_reg [NUM_CHANNELS];
    logic              fault_flag_reg     [NUM_CHANNELS];

    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg, out_data_next;

    logic [NUM_CHANNELS-1:0] sel;
    logic              cur_wait;
    logic [TICK_W-1:0] cur_rise;
    logic [TICK_W-1:0] cur_width;
    logic [MS_W-1:0]   cur_good;
    logic              cur_fault;

    logic [TICK_W-1:0] eff_min, eff_max;
    logic [TICK_W-1:0] w_direct;
    logic [TICK_W+1:0] w_wrap;
    logic [TICK_W-1:0] width;
    logic              width_fits;
    logic              width_ok;
    logic              is_rise, is_fall, good;
    logic [MS_W-1:0]   age;
    logic              stored_active;

    // take the next item when the output slot is free or being drained
    assign pop          = head_valid && (!out_valid_reg || result.ready);

    // window defaults
    assign eff_min = (cfg.valid_min_width == '0) ? DEF_MIN_WIDTH : cfg.valid_min_width;
    assign eff_max = (cfg.valid_max_width == '0 || cfg.valid_max_width < eff_min)
                     ? DEF_MAX_WIDTH : cfg.valid_max_width;

    always_comb
    begin
        cur_wait  = 1'b0;
        cur_rise  = '0;
        cur_width = '0;
        cur_good  = '0;
        cur_fault = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            sel[i] = head.ch_ok && (SEL_W'(head.channel) == SEL_W'(i));
            if (sel[i])
            begin
                cur_wait  = wait_falling_reg[i];
                cur_rise  = rise_stamp_reg[i];
                cur_width = held_width_reg[i];
                cur_good  = last_good_time_reg[i];
                cur_fault = fault_flag_reg[i];
            end
        end
    end

    // width: direct or wrapped once at the counter period; the wrapped form
    // is out of range when negative or above the tick range
    assign w_direct = head.capture_value - cur_rise;
    assign w_wrap   = {2'b00, cfg.counter_period} + (TICK_W+2)'(1)
                    - {2'b00, cur_rise} + {2'b00, head.capture_value};

    always_comb
    begin
        if (head.capture_value >= cur_rise)
        begin
            width      = w_direct;
            width_fits = 1'b1;
        end
        else
        begin
            width      = w_wrap[TICK_W-1:0];
            width_fits = w_wrap[TICK_W+1:TICK_W] == 2'b00;
        end
    end

    assign width_ok = width_fits && (width >= eff_min) && (width <= eff_max);
    assign is_rise  = head.ch_ok && (head.op == OP_CAPTURE) && !cur_wait;
    assign is_fall  = head.ch_ok && (head.op == OP_CAPTURE) && cur_wait;
    assign good     = is_fall && width_ok;

    assign age           = head.now_ms - cur_good;
    assign stored_active = (cur_good != '0) && (age <= cfg.activity_timeout_ms);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        out_data_next.out_channel = head.channel;
        if (!head.ch_ok)
        begin
            out_data_next.pulse_width      = '0;
            out_data_next.fault            = 1'b0;
            out_data_next.active           = 1'b0;
            out_data_next.width_updated    = 1'b0;
            out_data_next.awaiting_falling = 1'b0;
        end
        else
        begin
            out_data_next.pulse_width      = good ? width : cur_width;
            out_data_next.fault            = is_fall ? !width_ok : cur_fault;
            // a fresh good pulse has age zero; a stamp of zero reads as never
            out_data_next.active           = good ? (head.now_ms != '0) : stored_active;
            out_data_next.width_updated    = good;
            out_data_next.awaiting_falling = is_rise ? 1'b1 : (is_fall ? 1'b0 : cur_wait);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                wait_falling_reg[i]   <= 1'b0;
                rise_stamp_reg[i]     <= '0;
                held_width_reg[i]     <= RESET_WIDTH;
                last_good_time_reg[i] <= '0;
                fault_flag_reg[i]     <= 1'b0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (pop && sel[i])
                begin
                    if (is_rise)
                    begin
                        rise_stamp_reg[i]   <= head.capture_value;
                        wait_falling_reg[i] <= 1'b1;
                    end
                    else if (is_fall)
                    begin
                        wait_falling_reg[i] <= 1'b0;
                        fault_flag_reg[i]   <= !width_ok;
                        if (width_ok)
                        begin
                            held_width_reg[i]     <= width;
                            last_good_time_reg[i] <= head.now_ms;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.out_channel      = out_data_reg.out_channel;
    assign result.pulse_width      = out_data_reg.pulse_width;
    assign result.fault            = out_data_reg.fault;
    assign result.active           = out_data_reg.active;
    assign result.width_updated    = out_data_reg.width_updated;
    assign result.awaiting_falling = out_data_reg.awaiting_falling;

endmodule

@@ dv/rc_pulse_width_capture_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for rc_pulse_width_capture.
// Every item beat accepted on the input channel runs through a local channel
// model that produces the expected status beat. The monitor compares each
// result beat field by field against the oldest pending status.

module rc_pulse_width_capture_test;
    import rpwc_pkg::*;

    localparam int NUM_CH         = 3;
    localparam int SETTING_COUNT  = 6;
    localparam int ITEMS_PER_CFG  = 100;
    localparam int DRAIN_CYCLES   = 4;     // idle time added after the last status returns
    localparam int STALL_LIMIT    = 3000;  // cycles with no beat on either side
    localparam int HOLD_OFF_LEN   = 48;    // long receiver stall, queue is 2 deep
    localparam int REPORT_LIMIT   = 10;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rpwc_in_if  item_bus ();
    rpwc_out_if result_bus ();

    rc_pulse_width_capture #(
        .NUM_CHANNELS (NUM_CH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_bus),
        .result    (result_bus)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Channel model: local copy of the per-channel state and the
    // configuration registers, updated as beats are accepted.
    // ------------------------------------------------------------------
    cfg_t              shadow_cfg = '{RESET_PERIOD, 16'd0, 16'd0, RESET_TIMEOUT};
    logic              awaiting_fall [NUM_CH] = '{default: 1'b0};
    logic [TICK_W-1:0] rise_tick     [NUM_CH] = '{default: '0};
    logic [TICK_W-1:0] held_ticks    [NUM_CH] = '{default: RESET_WIDTH};
    logic [MS_W-1:0]   good_stamp    [NUM_CH] = '{default: '0};
    logic              width_fault   [NUM_CH] = '{default: 1'b0};

    result_t status_expected_q [$];

    int unsigned error_count   = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned hold_request  = 0;
    int unsigned hold_left     = 0;
    int unsigned stalled_cycles = 0;
    logic [MS_W-1:0] clock_ms  = '0;

    // Configurations walked by each random phase; corners included:
    // defaults, tiny period, narrow window, empty window with zero timeout,
    // zero period with the largest maximum and never-expiring timeout.
    cfg_t setting_table [SETTING_COUNT] = '{
        '{16'd65535, 16'd0,     16'd0,     32'd100},
        '{16'd999,   16'd0,     16'd0,     32'd5},
        '{16'd40000, 16'd1000,  16'd1900,  32'd1000},
        '{16'd65535, 16'd65535, 16'd0,     32'd0},
        '{16'd0,     16'd0,     16'd65535, 32'hFFFF_FFFF},
        '{16'd3000,  16'd1,     16'd65535, 32'd50}
    };

    // zero minimum falls back to the default
    function automatic int window_low();
        return (shadow_cfg.valid_min_width == 0) ? int'(DEF_MIN_WIDTH)
                                                 : int'(shadow_cfg.valid_min_width);
    endfunction

    // zero maximum, or one below the minimum, falls back to the default
    function automatic int window_high();
        int lo;
        lo = window_low();
        if (shadow_cfg.valid_max_width == 0 || int'(shadow_cfg.valid_max_width) < lo)
            return int'(DEF_MAX_WIDTH);
        return int'(shadow_cfg.valid_max_width);
    endfunction

    // Applies one beat to the channel model and returns the status it yields.
    function automatic result_t channel_status_after(op_t op, logic [CH_W-1:0] ch,
                                                     logic [TICK_W-1:0] cap,
                                                     logic [MS_W-1:0] now);
        result_t         st;
        longint          span;
        logic [MS_W-1:0] age;
        st = '0;
        st.out_channel = ch;
        if (ch >= NUM_CH)
            return st;    // unused channel: all-zero status, no state change
        if (op == OP_CAPTURE)
        begin
            if (!awaiting_fall[ch])
            begin
                rise_tick[ch]     = cap;
                awaiting_fall[ch] = 1'b1;
            end
            else
            begin
                // counter wrap; goes negative if the rise stamp sits past the period
                if (cap >= rise_tick[ch])
                    span = longint'(cap) - longint'(rise_tick[ch]);
                else
                    span = longint'(shadow_cfg.counter_period) + 1
                           - longint'(rise_tick[ch]) + longint'(cap);
                if (span <= 65535 && span >= window_low() && span <= window_high())
                begin
                    held_ticks[ch]  = span[TICK_W-1:0];
                    good_stamp[ch]  = now;
                    width_fault[ch] = 1'b0;
                    st.width_updated = 1'b1;
                end
                else
                    width_fault[ch] = 1'b1;
                awaiting_fall[ch] = 1'b0;
            end
        end
        age = now - good_stamp[ch];
        st.pulse_width      = held_ticks[ch];
        st.fault            = width_fault[ch];
        // a good stamp of zero reads as never updated
        st.active           = (good_stamp[ch] != 0) &&
                              (age <= shadow_cfg.activity_timeout_ms);
        st.awaiting_falling = awaiting_fall[ch];
        return st;
    endfunction

    function automatic string status_text(result_t st);
        return $sformatf("ch=%0d width=%0d fault=%b active=%b updated=%b wait_fall=%b",
                         st.out_channel, st.pulse_width, st.fault, st.active,
                         st.width_updated, st.awaiting_falling);
    endfunction

    task automatic note_failure(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Drivers. All tasks start and end just after a falling edge.
    // ------------------------------------------------------------------

    // Offers one item beat, with random idle cycles ahead of it, and records
    // the expected status once the beat is taken. Valid stays high on return
    // so back-to-back beats need no second assignment in one step.
    task automatic send_beat(op_t op, logic [CH_W-1:0] ch, logic [TICK_W-1:0] cap,
                             logic [MS_W-1:0] now);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.operation     <= op;
        item_bus.channel       <= ch;
        item_bus.capture_value <= cap;
        item_bus.now_ms        <= now;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        status_expected_q.push_back(channel_status_after(op, ch, cap, now));
        @(negedge clk);
    endtask

    // Stops offering beats and waits until every status has come back.
    task automatic drain_results();
        item_bus.valid <= 1'b0;
        while (status_expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        case (idx)
            CFG_COUNTER_PERIOD: shadow_cfg.counter_period      = data[TICK_W-1:0];
            CFG_VALID_MIN:      shadow_cfg.valid_min_width     = data[TICK_W-1:0];
            CFG_VALID_MAX:      shadow_cfg.valid_max_width     = data[TICK_W-1:0];
            CFG_TIMEOUT:        shadow_cfg.activity_timeout_ms = data;
            default: ;
        endcase
    endtask

    // Block must be idle before any register changes.
    task automatic apply_config(cfg_t c);
        drain_results();
        write_reg(CFG_COUNTER_PERIOD, CFG_DATA_W'(c.counter_period));
        write_reg(CFG_VALID_MIN,      CFG_DATA_W'(c.valid_min_width));
        write_reg(CFG_VALID_MAX,      CFG_DATA_W'(c.valid_max_width));
        write_reg(CFG_TIMEOUT,        c.activity_timeout_ms);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, or a counted hold-off when one is requested.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: one status beat per accepted item, in order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            seen.out_channel      = result_bus.out_channel;
            seen.pulse_width      = result_bus.pulse_width;
            seen.fault            = result_bus.fault;
            seen.active           = result_bus.active;
            seen.width_updated    = result_bus.width_updated;
            seen.awaiting_falling = result_bus.awaiting_falling;
            if (status_expected_q.size() == 0)
                note_failure({"status beat with nothing pending: ", status_text(seen)});
            else
            begin
                want = status_expected_q.pop_front();
                if (seen.out_channel !== want.out_channel ||
                    seen.pulse_width !== want.pulse_width ||
                    seen.fault !== want.fault ||
                    seen.active !== want.active ||
                    seen.width_updated !== want.width_updated ||
                    seen.awaiting_falling !== want.awaiting_falling)
                    note_failure({"status mismatch\n  expected ", status_text(want),
                                  "\n  actual   ", status_text(seen)});
            end
        end
    end

    // Watchdog: a run that stops moving beats is a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready) ||
            (result_bus.valid && result_bus.ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("rc_pulse_width_capture_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Fresh channels: reset width, no fault, never active; includes the
    // unused channel code and both extremes of the time stamp.
    task automatic test_idle_status();
        send_beat(OP_POLL, 2'd0, 16'd0,      32'd0);
        send_beat(OP_POLL, 2'd1, 16'hFFFF,   32'd0);
        send_beat(OP_POLL, 2'd2, 16'd0,      32'hFFFF_FFFF);
        send_beat(OP_POLL, 2'd3, 16'hFFFF,   32'hFFFF_FFFF);
    endtask

    // Good pulse, then polls right at and just past the activity timeout.
    task automatic test_pulse_and_timeout();
        send_beat(OP_CAPTURE, 2'd0, 16'd1000, 32'd1234);
        send_beat(OP_CAPTURE, 2'd0, 16'd2500, 32'd1234);
        send_beat(OP_POLL,    2'd0, 16'd0,    32'd1334);
        send_beat(OP_POLL,    2'd0, 16'd0,    32'd1335);
    endtask

    // Falling capture below the rising one: width wraps at the period.
    task automatic test_counter_wrap();
        send_beat(OP_CAPTURE, 2'd1, 16'd65000, 32'd7);
        send_beat(OP_CAPTURE, 2'd1, 16'd1000,  32'd7);
    endtask

    // Widest possible span faults; a pulse exactly at the minimum clears it.
    task automatic test_out_of_window_then_good();
        send_beat(OP_CAPTURE, 2'd2, 16'd0,     32'hFFFF_FFFF);
        send_beat(OP_CAPTURE, 2'd2, 16'hFFFF,  32'hFFFF_FFFF);
        send_beat(OP_CAPTURE, 2'd2, 16'd300,   32'd40);
        send_beat(OP_CAPTURE, 2'd2, 16'd1200,  32'd40);
    endtask

    // Good pulse (exactly the maximum) stamped at time zero reads as never
    // updated, so it is not active.
    task automatic test_good_pulse_at_time_zero();
        send_beat(OP_CAPTURE, 2'd1, 16'd10,   32'd0);
        send_beat(OP_CAPTURE, 2'd1, 16'd2110, 32'd0);
    endtask

    // Captures on the unused channel change nothing and report zeros.
    task automatic test_unused_channel();
        send_beat(OP_CAPTURE, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
        send_beat(OP_POLL,    2'd3, 16'hFFFF, 32'd5);
    endtask

    // Rise stamp past the period gives a negative span; a minimum above the
    // default maximum leaves an empty window.
    task automatic test_config_corners();
        apply_config('{16'd1000, 16'd0, 16'd0, 32'd100});
        send_beat(OP_CAPTURE, 2'd0, 16'd5000, 32'd60);
        send_beat(OP_CAPTURE, 2'd0, 16'd10,   32'd60);
        apply_config('{16'hFFFF, 16'd3000, 16'd0, 32'd100});
        send_beat(OP_CAPTURE, 2'd1, 16'd0,    32'd70);
        send_beat(OP_CAPTURE, 2'd1, 16'd2500, 32'd70);
    endtask

    // Receiver holds off while beats keep coming: the queue fills and the
    // input stalls. Then the sender waits for every status to return.
    task automatic test_backpressure();
        int unsigned saved_pct;
        drain_results();
        saved_pct    = src_idle_pct;
        src_idle_pct = 0;
        hold_request = HOLD_OFF_LEN;
        for (int i = 0; i < 20; i++)
            send_beat(op_t'(i % 2), CH_W'(i % NUM_CH), TICK_W'(i * 700), clock_ms + i);
        drain_results();
        src_idle_pct = saved_pct;
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed rise/fall pairs per channel with
    // widths aimed at the window and its edges, plus polls and noise.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(int unsigned src_pct, int unsigned sink_pct);
        int unsigned       pick;
        logic [CH_W-1:0]   ch;
        logic [TICK_W-1:0] cap;
        logic [MS_W-1:0]   now;
        longint            span_goal;
        longint            fall_at;
        int                lo;
        int                hi;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int s = 0; s < SETTING_COUNT; s++)
        begin
            apply_config(setting_table[s]);
            repeat (ITEMS_PER_CFG)
            begin
                if ($urandom_range(0, 19) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms += $urandom_range(0, 40);
                now  = clock_ms;
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    // noise: any operation, channel and capture value
                    send_beat(op_t'($urandom_range(0, 1)), CH_W'($urandom_range(0, 3)),
                              TICK_W'($urandom), now);
                end
                else if (pick < 25)
                begin
                    ch = CH_W'($urandom_range(0, 3));
                    // for a used channel, one poll in three lands right at or just past the timeout boundary
                    if (ch < NUM_CH && $urandom_range(0, 2) == 0)
                        now = good_stamp[ch] + shadow_cfg.activity_timeout_ms +
                              $urandom_range(0, 1);
                    send_beat(OP_POLL, ch, TICK_W'($urandom), now);
                end
                else
                begin
                    ch = CH_W'($urandom_range(0, NUM_CH - 1));
                    if (!awaiting_fall[ch])
                    begin
                        if ($urandom_range(0, 4) != 0)
                            cap = TICK_W'($urandom_range(0, shadow_cfg.counter_period));
                        else
                            cap = TICK_W'($urandom);
                    end
                    else
                    begin
                        lo = window_low();
                        hi = window_high();
                        case ($urandom_range(0, 9))
                            6:       span_goal = lo - 1;
                            7:       span_goal = hi + 1;
                            8:       span_goal = ($urandom_range(0, 1) != 0) ? lo : hi;
                            9:       span_goal = $urandom_range(0, 65535);
                            default: span_goal = (lo <= hi) ? $urandom_range(lo, hi)
                                                            : $urandom_range(0, 65535);
                        endcase
                        fall_at = longint'(rise_tick[ch]) + span_goal;
                        if (fall_at > longint'(shadow_cfg.counter_period))
                            fall_at -= longint'(shadow_cfg.counter_period) + 1;
                        cap = fall_at[TICK_W-1:0];
                    end
                    send_beat(OP_CAPTURE, ch, cap, now);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_COUNTER_PERIOD;
        cfg_wdata              = '0;
        item_bus.valid         = 1'b0;
        item_bus.operation     = OP_CAPTURE;
        item_bus.channel       = '0;
        item_bus.capture_value = '0;
        item_bus.now_ms        = '0;
        result_bus.ready       = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_status();
        test_pulse_and_timeout();
        test_counter_wrap();
        test_out_of_window_then_good();
        test_good_pulse_at_time_zero();
        test_unused_channel();
        test_config_corners();

        test_random_traffic(30, 56);
        test_backpressure();
        test_random_traffic(56, 30);
        test_random_traffic(0, 0);

        drain_results();
        if (error_count == 0 && status_expected_q.size() == 0)
            $display("rc_pulse_width_capture_test passed");
        else
            $display("rc_pulse_width_capture_test failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/rpwc_pkg.sv
design/rpwc_in_if.sv
design/rpwc_out_if.sv
design/rpwc_front.sv
design/rpwc_queue.sv
design/rpwc_back.sv
design/rc_pulse_width_capture.sv
dv/rc_pulse_width_capture_test.sv
